// ===== hdl/control_code_diff_tokenizer_macros.svh =====
// assertion macros for the control code diff tokenizer
// used by the top level only; expects clk and rst in scope
`ifndef CONTROL_CODE_DIFF_TOKENIZER_MACROS_SVH
`define CONTROL_CODE_DIFF_TOKENIZER_MACROS_SVH

// implication within the same cycle
`define CCDT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define CCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ccdt_pkg.sv =====
// types and constants for the control code diff tokenizer
// no dependencies
`default_nettype none

package ccdt_pkg;

  localparam logic [7:0] CC_EOT   = 8'h04;
  localparam logic [7:0] CC_DLE   = 8'h10;
  localparam logic [7:0] CC_SUB   = 8'h1A;
  localparam logic [7:0] CC_FS    = 8'h1C;
  localparam logic [7:0] CC_GS    = 8'h1D;
  localparam logic [7:0] CC_US    = 8'h1F;
  localparam logic [7:0] PATH_MIN = 8'h20;

  localparam logic [2:0] EV_FILE    = 3'd0;
  localparam logic [2:0] EV_PATH    = 3'd1;
  localparam logic [2:0] EV_SECTION = 3'd2;
  localparam logic [2:0] EV_SPAN    = 3'd3;
  localparam logic [2:0] EV_ANCHOR  = 3'd4;
  localparam logic [2:0] EV_OLD     = 3'd5;
  localparam logic [2:0] EV_NEW     = 3'd6;
  localparam logic [2:0] EV_DONE    = 3'd7;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PATH = 2'd1;
  localparam logic [1:0] MODE_BODY = 2'd2;
  localparam logic [1:0] MODE_SECT = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       esc;
    logic       started;
    logic       sub;
    logic       fin;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } event_t;

  typedef struct packed {
    logic [1:0]   count;
    event_t       first;
    event_t       second;
    parse_state_t state_next;
  } step_t;

endpackage

`default_nettype wire

// ===== hdl/ccdt_decode.sv =====
// per-byte decode: next parse state and up to two events for one transaction
// depends on ccdt_pkg
`default_nettype none

module ccdt_decode (
  input  wire ccdt_pkg::parse_state_t state,
  input  wire logic [7:0]             byte_value,
  input  wire logic                   end_mark,
  output      ccdt_pkg::step_t        step
);
  import ccdt_pkg::*;

  parse_state_t st;
  logic         pre_v;
  logic [2:0]   pre_k;
  logic         main_v;
  logic [2:0]   main_k;
  logic [7:0]   main_b;
  logic         do_body;
  logic         do_close;

  always_comb begin
    st       = state;
    pre_v    = 1'b0;
    pre_k    = EV_ANCHOR;
    main_v   = 1'b0;
    main_k   = EV_DONE;
    main_b   = 8'h00;
    do_body  = 1'b0;
    do_close = 1'b0;

    if (end_mark) begin
      if (!state.fin) begin
        do_close = (state.mode == MODE_SECT);
        main_v   = 1'b1;
        main_k   = EV_DONE;
      end
    end else if (!state.fin) begin
      unique case (state.mode)
        MODE_IDLE: begin
          if (byte_value == CC_FS || byte_value == CC_EOT) begin
            do_body = 1'b1;
          end
        end
        MODE_PATH: begin
          if (byte_value >= PATH_MIN) begin
            main_v = 1'b1;
            main_k = EV_PATH;
            main_b = byte_value;
          end else begin
            st.mode = MODE_BODY;
            do_body = 1'b1;
          end
        end
        MODE_BODY: begin
          do_body = 1'b1;
        end
        MODE_SECT: begin
          priority if (state.esc) begin
            st.esc = 1'b0;
            main_v = 1'b1;
            main_k = EV_SPAN;
            main_b = byte_value;
          end else if (byte_value == CC_GS || byte_value == CC_FS ||
                       byte_value == CC_EOT) begin
            do_close = 1'b1;
            do_body  = 1'b1;
          end else if (byte_value == CC_US) begin
            do_close = 1'b1;
          end else if (byte_value == CC_SUB) begin
            if (state.started) begin
              main_v = 1'b1;
              main_k = EV_OLD;
              st.sub = 1'b1;
            end
            st.started = 1'b0;
          end else if (byte_value == CC_DLE) begin
            st.started = 1'b1;
            st.esc     = 1'b1;
          end else begin
            st.started = 1'b1;
            main_v     = 1'b1;
            main_k     = EV_SPAN;
            main_b     = byte_value;
          end
        end
      endcase
    end

    // close an open span ahead of the main event
    if (do_close) begin
      if (st.started) begin
        pre_v = 1'b1;
        if (st.sub) begin
          pre_k  = EV_NEW;
          st.sub = 1'b0;
        end else begin
          pre_k = EV_ANCHOR;
        end
      end
      st.started = 1'b0;
      st.esc     = 1'b0;
    end

    if (do_body) begin
      priority if (byte_value == CC_FS) begin
        main_v  = 1'b1;
        main_k  = EV_FILE;
        st.mode = MODE_PATH;
        st.sub  = 1'b0;
      end else if (byte_value == CC_GS && st.mode != MODE_IDLE) begin
        main_v     = 1'b1;
        main_k     = EV_SECTION;
        st.mode    = MODE_SECT;
        st.sub     = 1'b0;
        st.started = 1'b0;
        st.esc     = 1'b0;
      end else if (byte_value == CC_EOT) begin
        main_v = 1'b1;
        main_k = EV_DONE;
        st.fin = 1'b1;
      end else begin
        main_v = 1'b0;
      end
    end

    // end of buffer always returns to idle
    if (end_mark) begin
      st = '0;
    end

    step.state_next = st;
    step.count      = {1'b0, pre_v} + {1'b0, main_v};
    if (pre_v) begin
      step.first  = '{kind: pre_k, data: 8'h00};
      step.second = '{kind: main_k, data: main_b};
    end else begin
      step.first  = '{kind: main_k, data: main_b};
      step.second = '{kind: main_k, data: main_b};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/control_code_diff_tokenizer.sv =====
// top level of the control code diff tokenizer: parse state and result buffer
// depends on ccdt_pkg, ccdt_decode and control_code_diff_tokenizer_macros.svh
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------
//  input   | in_valid / in_ready | byte_value, end_mark
//  output  | out_valid/out_ready | event_kind, data_byte, last_of_run
//
// one byte per cycle while in_ready is high; its events are registered and appear the next cycle
// a byte that yields two events holds the result buffer until both events have left
// in_ready is high when the buffer is empty or its last event leaves this cycle
// rst clears the parse state and empties the buffer
// output stalls back up into in_ready only, never into the parse state
`default_nettype none

`include "control_code_diff_tokenizer_macros.svh"

module control_code_diff_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_mark,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] event_kind,
  output      logic [7:0] data_byte,
  output      logic       last_of_run
);
  import ccdt_pkg::*;

  parse_state_t state;
  step_t        step;
  event_t       slot0;
  event_t       slot1;
  logic         slot0_last;
  logic [1:0]   cnt;
  logic         accept;
  logic         pop;

  ccdt_decode u_decode (
    .state      (state),
    .byte_value (byte_value),
    .end_mark   (end_mark),
    .step       (step)
  );

  assign out_valid   = (cnt != 2'd0);
  assign pop         = out_valid && out_ready;
  assign in_ready    = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign accept      = in_valid && in_ready;
  assign event_kind  = slot0.kind;
  assign data_byte   = slot0.data;
  assign last_of_run = slot0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= step.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= step.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0      <= step.first;
      slot1      <= step.second;
      slot0_last <= (step.count == 2'd1);
    end else if (pop && cnt == 2'd2) begin
      slot0      <= slot1;
      slot0_last <= 1'b1;
    end
  end

  // transaction with a follower must have it buffered
  `CCDT_ASSERT_SAME(a_pair_held, out_valid && !last_of_run, cnt == 2'd2,
    "non-final event without its follower")
  // end of buffer always leaves idle, unfinished state
  `CCDT_ASSERT_NEXT(a_end_idle, accept && end_mark,
    state.mode == MODE_IDLE && !state.fin && !state.sub,
    "end of buffer did not return to idle")
  // only path and span events carry a byte
  `CCDT_ASSERT_SAME(a_data_zero,
    out_valid && event_kind != EV_PATH && event_kind != EV_SPAN, data_byte == 8'h00,
    "control event carries data")

endmodule

`default_nettype wire

// ===== verif/control_code_diff_tokenizer_checker.sv =====
// event checker for the control code diff tokenizer: predicts the events of every
// accepted byte and compares them in order with the output channel
// depends on ccdt_pkg
`timescale 1ns / 1ps

module control_code_diff_tokenizer_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_mark,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [2:0] event_kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_of_run,
  output int              error_count,
  output int              pending_count,
  output int              active_items,
  output int              events_checked,
  output int              swap_count
);
  import ccdt_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  parse_state_t tok;
  token_t       expected_events[$];
  token_t       step_buf[2];
  int           step_n;
  token_t       want;
  int           errs = 0;
  int           checked = 0;
  int           swaps = 0;
  int           active = 0;

  function automatic void emit(logic [2:0] kind, logic [7:0] data);
    if (step_n < 2) begin
      step_buf[step_n] = {kind, data, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void close_span();
    if (tok.started) begin
      if (tok.sub) begin
        emit(EV_NEW, 8'h00);
        tok.sub = 1'b0;
      end else begin
        emit(EV_ANCHOR, 8'h00);
      end
    end
    tok.started = 1'b0;
    tok.esc = 1'b0;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    if (b == CC_FS) begin
      emit(EV_FILE, 8'h00);
      tok.mode = MODE_PATH;
      tok.sub = 1'b0;
    end else if (b == CC_GS) begin
      emit(EV_SECTION, 8'h00);
      tok.mode = MODE_SECT;
      tok.sub = 1'b0;
      tok.started = 1'b0;
      tok.esc = 1'b0;
    end else if (b == CC_EOT) begin
      emit(EV_DONE, 8'h00);
      tok.fin = 1'b1;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic end_of_buf);
    step_n = 0;
    if (end_of_buf) begin
      if (!tok.fin) begin
        if (tok.mode == MODE_SECT) close_span();
        emit(EV_DONE, 8'h00);
      end
      tok = '0;
    end else if (!tok.fin) begin
      case (tok.mode)
        MODE_IDLE: begin
          if (b == CC_FS || b == CC_EOT) body_byte(b);
        end
        MODE_PATH: begin
          if (b >= PATH_MIN) begin
            emit(EV_PATH, b);
          end else begin
            tok.mode = MODE_BODY;
            body_byte(b);
          end
        end
        MODE_BODY: begin
          body_byte(b);
        end
        default: begin
          if (tok.esc) begin
            tok.esc = 1'b0;
            emit(EV_SPAN, b);
          end else if (b == CC_GS || b == CC_FS || b == CC_EOT) begin
            close_span();
            body_byte(b);
          end else if (b == CC_US) begin
            close_span();
          end else if (b == CC_SUB) begin
            if (tok.started) begin
              emit(EV_OLD, 8'h00);
              tok.sub = 1'b1;
            end
            tok.started = 1'b0;
          end else if (b == CC_DLE) begin
            tok.started = 1'b1;
            tok.esc = 1'b1;
          end else begin
            tok.started = 1'b1;
            emit(EV_SPAN, b);
          end
        end
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      step_buf[i].last = (i == step_n - 1);
      expected_events.push_back(step_buf[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tok = '0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event with no transaction waiting: event_kind %0d data_byte %02h",
                 event_kind, data_byte);
          errs++;
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
            errs++;
          end
          if (data_byte !== want.data) begin
            $error("data_byte: expected %02h, actual %02h", want.data, data_byte);
            errs++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
            errs++;
          end
          checked++;
          if (want.kind == EV_NEW) swaps++;
        end
      end
      if (in_valid && in_ready) begin
        tokenize_byte(byte_value, end_mark);
        active++;
      end
    end
    error_count <= errs;
    pending_count <= expected_events.size();
    active_items <= active;
    events_checked <= checked;
    swap_count <= swaps;
  end

endmodule

// ===== verif/control_code_diff_tokenizer_tb.sv =====
// testbench top for the control code diff tokenizer: clock, reset, byte stimulus
// with bursty input and a stalling receiver, verdict from the event checker
// depends on ccdt_pkg, control_code_diff_tokenizer and its checker
`timescale 1ns / 1ps

module control_code_diff_tokenizer_tb;
  import ccdt_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic       end_mark = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [2:0] event_kind;
  wire  [7:0] data_byte;
  wire        last_of_run;

  int error_count;
  int pending_count;
  int active_items;
  int events_checked;
  int swap_count;

  int burst_left = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;
  int idle_cycles = 0;
  int docs = 0;

  control_code_diff_tokenizer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_value  (byte_value),
    .end_mark    (end_mark),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .data_byte   (data_byte),
    .last_of_run (last_of_run)
  );

  control_code_diff_tokenizer_checker events_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_value     (byte_value),
    .end_mark       (end_mark),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .data_byte      (data_byte),
    .last_of_run    (last_of_run),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .active_items   (active_items),
    .events_checked (events_checked),
    .swap_count     (swap_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stall patterns, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_phase <= $urandom_range(16, 96);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (stall_phase % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    byte_value <= b;
    end_mark <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    logic [7:0] b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_byte(CC_GS, 1'b0);
    send_byte(CC_FS, 1'b0);
    send_byte(PATH_MIN, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(CC_GS, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CC_DLE, 1'b0);
    send_byte(CC_US, 1'b0);
    send_byte(CC_SUB, 1'b0);
    send_byte(CC_SUB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CC_SUB, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(CC_US, 1'b0);
    send_byte(CC_US, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(CC_SUB, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(CC_GS, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(CC_FS, 1'b0);
    send_byte(CC_GS, 1'b0);
    send_byte(CC_DLE, 1'b0);
    send_byte(CC_EOT, 1'b0);
    send_byte(8'h65, 1'b0);
    send_byte(CC_EOT, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(CC_FS, 1'b0);
    send_byte(CC_GS, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(CC_DLE, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // random documents, with some noise and broken streams
    while (active_items < ITEM_TARGET) begin
      docs++;
      if (docs % 40 == 7) hold_reqs <= hold_reqs + 1;
      if (docs % 25 == 0) wait_drained();
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(4, 24))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(CC_FS, 1'b0);
          repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(PATH_MIN, 8'hFF)), 1'b0);
          if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 8'h1F)), 1'b0);
          repeat ($urandom_range(1, 3)) begin
            send_byte(CC_GS, 1'b0);
            repeat ($urandom_range(1, 6)) begin
              repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 5) == 0) begin
                  send_byte(CC_DLE, 1'b0);
                  send_byte(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CC_EOT || b == CC_DLE || b == CC_SUB || b == CC_FS || b == CC_GS ||
                      b == CC_US) b = b ^ 8'h40;
                  send_byte(b, 1'b0);
                end
              end
              if ($urandom_range(0, 5) != 0)
                send_byte(($urandom_range(0, 4) < 2) ? CC_SUB : CC_US, 1'b0);
            end
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          send_byte(CC_EOT, 1'b0);
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if ($urandom_range(0, 5) == 0) begin
          send_byte(CC_DLE, 1'b0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bytes over %0d random documents and directed cases; %0d events checked,",
             active_items, docs, events_checked);
    $display("%0d substitutions closed by a new span", swap_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
